>>> src/kcd_pkg.sv
`timescale 1ns / 1ps
package kcd_pkg;

	// sizes
	localparam int NKEYS  = 3;
	localparam int MAXRES = 3;

	// event kinds on the input side
	localparam logic [1:0] KIND_PRESS   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_TICK    = 2'd2;

	// result actions
	localparam logic [2:0] ACT_PASS  = 3'd0;
	localparam logic [2:0] ACT_REG   = 3'd1;
	localparam logic [2:0] ACT_UNREG = 3'd2;
	localparam logic [2:0] ACT_TAP   = 3'd3;
	localparam logic [2:0] ACT_FIRE  = 3'd4;

	// chord key slots
	localparam logic [1:0] KEY_ANCHOR  = 2'd0;
	localparam logic [1:0] KEY_PROFILE = 2'd1;
	localparam logic [1:0] KEY_RGB     = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_SYNC_MS     = 3'd0;
	localparam logic [2:0] REG_HOLD_MS     = 3'd1;
	localparam logic [2:0] REG_ANCHOR_ROW  = 3'd2;
	localparam logic [2:0] REG_ANCHOR_COL  = 3'd3;
	localparam logic [2:0] REG_PROFILE_ROW = 3'd4;
	localparam logic [2:0] REG_PROFILE_COL = 3'd5;
	localparam logic [2:0] REG_RGB_ROW     = 3'd6;
	localparam logic [2:0] REG_RGB_COL     = 3'd7;

	typedef struct packed {
		logic [4:0] row;
		logic [4:0] col;
	} kcd_pos_t;

	typedef struct packed {
		logic [15:0] sync_ms;
		logic [15:0] hold_ms;
		kcd_pos_t    anchor;
		kcd_pos_t    profile;
		kcd_pos_t    rgb;
	} kcd_cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  row;
		logic [4:0]  col;
		logic [15:0] code;
	} kcd_item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] code;
		logic        pressed;
		logic        chord;
	} kcd_res_t;

	// handoff from the evaluator to the result buffer
	typedef struct packed {
		logic       load;
		logic [1:0] cnt;
	} kcd_load_t;

endpackage

>>> src/kcd_core.sv
`timescale 1ns / 1ps
module kcd_core #(
	parameter int TIMER_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  kcd_pkg::kcd_cfg_t                     cfg,
	input  kcd_pkg::kcd_item_t                    item,
	input  logic                                  go,
	output kcd_pkg::kcd_res_t [kcd_pkg::MAXRES-1:0] res,
	output kcd_pkg::kcd_load_t                    load
);
	import kcd_pkg::*;

	localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	// per-key flags
	logic [NKEYS-1:0] down_q, withheld_q, fwd_q, consumed_q;
	logic [NKEYS-1:0] down_n, withheld_n, fwd_n, consumed_n;
	logic [15:0]           saved_q [NKEYS];
	logic [15:0]           saved_n [NKEYS];
	logic [TIMER_BITS-1:0] stamp_q [NKEYS];
	logic [TIMER_BITS-1:0] stamp_n [NKEYS];
	logic                  armed_q, armed_n;
	logic                  aidx_q, aidx_n;
	logic [TIMER_BITS-1:0] astamp_q, astamp_n;
	logic [TIMER_BITS-1:0] ms_q, ms_n;

	kcd_res_t [MAXRES-1:0] res_n;
	logic [1:0]            cnt_n;

	// key lookup, anchor first
	logic       hit_a, hit_p, hit_r, is_chord;
	logic [1:0] kidx;

	always_comb begin
		hit_a = (item.row == cfg.anchor.row) && (item.col == cfg.anchor.col);
		hit_p = (item.row == cfg.profile.row) && (item.col == cfg.profile.col);
		hit_r = (item.row == cfg.rgb.row) && (item.col == cfg.rgb.col);
		is_chord = hit_a || hit_p || hit_r;
		priority if (hit_a) begin
			kidx = KEY_ANCHOR;
		end else if (hit_p) begin
			kidx = KEY_PROFILE;
		end else begin
			kidx = KEY_RGB;
		end
	end

	// evaluate one event against the key state
	always_comb begin : eval
		logic [1:0]            n;
		logic [1:0]            p;
		logic [1:0]            partner;
		logic [TIMER_BITS-1:0] el;
		down_n     = down_q;
		withheld_n = withheld_q;
		fwd_n      = fwd_q;
		consumed_n = consumed_q;
		saved_n    = saved_q;
		stamp_n    = stamp_q;
		armed_n    = armed_q;
		aidx_n     = aidx_q;
		astamp_n   = astamp_q;
		ms_n       = ms_q;
		res_n      = '0;
		n          = 2'd0;
		p          = aidx_q ? KEY_RGB : KEY_PROFILE;
		partner    = KEY_ANCHOR;
		el         = '0;

		if (item.kind == KIND_TICK) begin
			ms_n = ms_q + 1'b1;
			if (armed_q) begin
				el = ms_n - astamp_q;
				if (CW'(el) >= CW'(cfg.hold_ms)) begin
					armed_n                = 1'b0;
					withheld_n[KEY_ANCHOR] = 1'b0;
					withheld_n[p]          = 1'b0;
					consumed_n[KEY_ANCHOR] = 1'b1;
					consumed_n[p]          = 1'b1;
					res_n[n] = '{action: ACT_FIRE, code: 16'd0, pressed: 1'b0,
						chord: aidx_q};
					n = n + 2'd1;
				end
			end else begin
				// forward withheld keys whose sync window ran out
				for (int k = 0; k < NKEYS; k++) begin
					el = ms_n - stamp_q[k];
					if (down_q[k] && withheld_q[k] && CW'(el) >= CW'(cfg.sync_ms)) begin
						withheld_n[k] = 1'b0;
						fwd_n[k]      = 1'b1;
						res_n[n] = '{action: ACT_REG, code: saved_q[k], pressed: 1'b0,
							chord: 1'b0};
						n = n + 2'd1;
					end
				end
			end
		end else if (item.kind == KIND_PRESS || item.kind == KIND_RELEASE) begin
			if (!is_chord) begin
				res_n[n] = '{action: ACT_PASS, code: item.code,
					pressed: (item.kind == KIND_PRESS), chord: 1'b0};
				n = n + 2'd1;
			end else if (item.kind == KIND_PRESS) begin
				down_n[kidx]     = 1'b1;
				withheld_n[kidx] = 1'b1;
				fwd_n[kidx]      = 1'b0;
				consumed_n[kidx] = 1'b0;
				saved_n[kidx]    = item.code;
				stamp_n[kidx]    = ms_q;
				if (!armed_q) begin
					priority if (down_n[KEY_ANCHOR] && withheld_n[KEY_ANCHOR] &&
						down_n[KEY_PROFILE] && withheld_n[KEY_PROFILE]) begin
						armed_n  = 1'b1;
						aidx_n   = 1'b0;
						astamp_n = ms_q;
					end else if (down_n[KEY_ANCHOR] && withheld_n[KEY_ANCHOR] &&
						down_n[KEY_RGB] && withheld_n[KEY_RGB]) begin
						armed_n  = 1'b1;
						aidx_n   = 1'b1;
						astamp_n = ms_q;
					end else begin
						armed_n = 1'b0;
					end
				end
			end else begin
				down_n[kidx] = 1'b0;
				if (consumed_q[kidx]) begin
					consumed_n[kidx] = 1'b0;
					withheld_n[kidx] = 1'b0;
				end else begin
					// early release of an armed chord key disarms it
					if (armed_q && (kidx == KEY_ANCHOR || kidx == p)) begin
						partner = (kidx == KEY_ANCHOR) ? p : KEY_ANCHOR;
						armed_n = 1'b0;
						if (down_n[partner] && withheld_n[partner]) begin
							withheld_n[partner] = 1'b0;
							fwd_n[partner]      = 1'b1;
							res_n[n] = '{action: ACT_REG, code: saved_q[partner],
								pressed: 1'b0, chord: 1'b0};
							n = n + 2'd1;
						end
					end
					if (withheld_n[kidx]) begin
						withheld_n[kidx] = 1'b0;
						res_n[n] = '{action: ACT_TAP, code: saved_q[kidx], pressed: 1'b0,
							chord: 1'b0};
						n = n + 2'd1;
					end else if (fwd_n[kidx]) begin
						fwd_n[kidx] = 1'b0;
						res_n[n] = '{action: ACT_UNREG, code: saved_q[kidx],
							pressed: 1'b0, chord: 1'b0};
						n = n + 2'd1;
					end
				end
			end
		end
		cnt_n = n;
	end

	assign res  = res_n;
	assign load = '{load: go, cnt: cnt_n};

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q     <= '0;
			withheld_q <= '0;
			fwd_q      <= '0;
			consumed_q <= '0;
			armed_q    <= 1'b0;
			aidx_q     <= 1'b0;
			ms_q       <= '0;
		end else if (go) begin
			down_q     <= down_n;
			withheld_q <= withheld_n;
			fwd_q      <= fwd_n;
			consumed_q <= consumed_n;
			armed_q    <= armed_n;
			aidx_q     <= aidx_n;
			ms_q       <= ms_n;
		end
	end

	// codes and stamps
	always_ff @(posedge clk) begin
		if (go) begin
			saved_q  <= saved_n;
			stamp_q  <= stamp_n;
			astamp_q <= astamp_n;
		end
	end

	// a withheld key is always down
	assert property (@(posedge clk) disable iff (!arst_n)
		(withheld_q & ~down_q) == '0)
		else $error("withheld key not down");

	// a key is never withheld and forwarded at once
	assert property (@(posedge clk) disable iff (!arst_n)
		(withheld_q & fwd_q) == '0)
		else $error("key withheld and forwarded");

	// an armed chord keeps its anchor down and withheld
	assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> (down_q[KEY_ANCHOR] && withheld_q[KEY_ANCHOR]))
		else $error("armed chord without held anchor");

endmodule

>>> src/kcd_out.sv
`timescale 1ns / 1ps
module kcd_out (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  kcd_pkg::kcd_res_t [kcd_pkg::MAXRES-1:0] res,
	input  kcd_pkg::kcd_load_t                    load,
	output logic                                  free,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [23:0]                           m_tdata,  // out_code, out_pressed, chord_index
	output logic [2:0]                            m_tuser,  // action
	output logic                                  m_tlast
);
	import kcd_pkg::*;

	kcd_res_t [MAXRES-1:0] buf_q;
	logic [1:0]            cnt_q;
	logic [1:0]            idx_q;
	logic                  beat, at_last;
	kcd_res_t              cur;

	assign cur      = buf_q[idx_q];
	assign m_tvalid = (cnt_q != 2'd0);
	assign at_last  = (idx_q == cnt_q - 2'd1);
	assign beat     = m_tvalid && m_tready;
	assign free     = !m_tvalid || (beat && at_last);

	assign m_tdata = {6'd0, cur.chord, cur.pressed, cur.code};
	assign m_tuser = cur.action;
	assign m_tlast = at_last;

	// result buffer payload
	always_ff @(posedge clk) begin
		if (load.load) begin
			buf_q <= res;
		end
	end

	// fill count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load.load) begin
			cnt_q <= load.cnt;
			idx_q <= 2'd0;
		end else if (beat) begin
			if (at_last) begin
				cnt_q <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// read pointer stays inside the filled part
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (idx_q < cnt_q))
		else $error("read pointer past fill count");

	// a new batch only lands on an empty or draining buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		load.load |-> free)
		else $error("result buffer overwritten");

endmodule

>>> src/key_chord_detector_unit.sv
`timescale 1ns / 1ps
// Events wait in the input register until the result buffer is free, then their
// up to three results are registered there. Throughput: one event per cycle while
// the buffer is free; a batch frees it as its last result is taken at the port.
// Reset (arst_n low, asynchronous): key flags, chord arming and the ms counter
// clear, config registers take their defaults, both channels go idle.
module key_chord_detector_unit #(
	parameter int TIMER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // key_row, key_col, key_code
	input  logic [1:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_code, out_pressed, chord_index
	output logic [2:0]  m_tuser,   // action
	output logic        m_tlast
);
	import kcd_pkg::*;

	kcd_cfg_t              cfg_q;
	kcd_item_t             item_s1;
	logic                  v_s1;
	logic                  go, free;
	kcd_res_t [MAXRES-1:0] res;
	kcd_load_t             load;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_ms     <= 16'd50;
			cfg_q.hold_ms     <= 16'd1000;
			cfg_q.anchor.row  <= 5'd3;
			cfg_q.anchor.col  <= 5'd0;
			cfg_q.profile.row <= 5'd3;
			cfg_q.profile.col <= 5'd5;
			cfg_q.rgb.row     <= 5'd2;
			cfg_q.rgb.col     <= 5'd5;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SYNC_MS:     cfg_q.sync_ms     <= cfg_wdata;
				REG_HOLD_MS:     cfg_q.hold_ms     <= cfg_wdata;
				REG_ANCHOR_ROW:  cfg_q.anchor.row  <= cfg_wdata[4:0];
				REG_ANCHOR_COL:  cfg_q.anchor.col  <= cfg_wdata[4:0];
				REG_PROFILE_ROW: cfg_q.profile.row <= cfg_wdata[4:0];
				REG_PROFILE_COL: cfg_q.profile.col <= cfg_wdata[4:0];
				REG_RGB_ROW:     cfg_q.rgb.row     <= cfg_wdata[4:0];
				REG_RGB_COL:     cfg_q.rgb.col     <= cfg_wdata[4:0];
			endcase
		end
	end

	// input register: evaluated once the result buffer can take its batch
	assign go       = v_s1 && free;
	assign s_tready = !v_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{kind: s_tuser, row: s_tdata[4:0], col: s_tdata[9:5],
				code: s_tdata[25:10]};
		end
	end

	kcd_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.item  (item_s1),
		.go    (go),
		.res   (res),
		.load  (load)
	);

	kcd_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.res     (res),
		.load    (load),
		.free    (free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule
